>>> src/mpwc_pkg.sv
// shared types, widths and constants of the multichannel pulse width capture block
package mpwc_pkg;

   localparam int CHANNELS_DEFAULT = 18;
   localparam int CHANNEL_W        = 5;
   localparam int TIME_W           = 32;
   localparam int WIDTH_W          = 16;
   localparam int COUNT_W          = 32;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 16;

   localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 16'd500;
   localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 16'd2500;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MONITOR_ENABLE = 2'd0,
      CSR_MIN_WIDTH      = 2'd1,
      CSR_MAX_WIDTH      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               monitor_enable;
      logic [WIDTH_W-1:0] min_width_us;
      logic [WIDTH_W-1:0] max_width_us;
   } csr_type;

   // one channel entry of the state memory
   typedef struct packed {
      logic [TIME_W-1:0]  rise_time;
      logic               rise_seen;
      logic [WIDTH_W-1:0] width;
      logic [COUNT_W-1:0] count;
      logic               width_valid;
   } entry_type;

endpackage

>>> src/mpwc_if.sv
// request and response channel interfaces
interface mpwc_req_if import mpwc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] channel;
   logic                 rise_event;
   logic                 fall_event;
   logic [TIME_W-1:0]    timestamp_us;

   modport source (output valid, channel, rise_event, fall_event, timestamp_us,
                   input ready);
   modport sink   (input valid, channel, rise_event, fall_event, timestamp_us,
                   output ready);
endinterface

interface mpwc_rsp_if import mpwc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] channel_out;
   logic [WIDTH_W-1:0]   high_width_us;
   logic [COUNT_W-1:0]   accept_count;
   logic                 width_valid;
   logic                 captured;
   logic                 ignored;

   modport source (output valid, channel_out, high_width_us, accept_count, width_valid,
                   captured, ignored, input ready);
   modport sink   (input valid, channel_out, high_width_us, accept_count, width_valid,
                   captured, ignored, output ready);
endinterface

>>> src/mpwc_csr.sv
// configuration registers
module mpwc_csr import mpwc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output csr_type                csr_q
);

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MONITOR_ENABLE: csr_in.monitor_enable = csr_wdata[0];
            CSR_MIN_WIDTH:      csr_in.min_width_us   = csr_wdata[WIDTH_W-1:0];
            CSR_MAX_WIDTH:      csr_in.max_width_us   = csr_wdata[WIDTH_W-1:0];
            default:            csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.monitor_enable <= 1'b0;
         csr_ff.min_width_us   <= MIN_WIDTH_RESET;
         csr_ff.max_width_us   <= MAX_WIDTH_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr_q = csr_ff;

endmodule

>>> src/mpwc_core.sv
// channel state memory with read-modify-write pipeline and output register
module mpwc_core import mpwc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  csr_type    csr_q,
   mpwc_req_if.sink   req_ch,
   mpwc_rsp_if.source rsp_ch
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W = 7;

   // state memory and per-entry written flags (unwritten entries read as zero)
   entry_type         mem [CHANNELS];
   logic [CHANNELS-1:0] written_ff;

   // request decode
   logic [IDX_W+CHANNEL_W-1:0] req_ext;
   logic [IDX_W-1:0]           req_addr;
   logic                       req_in_range;
   logic                       req_acc;

   // read stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [CHANNEL_W-1:0] s1_channel_ff;
   logic [IDX_W-1:0]     s1_addr_ff;
   logic                 s1_in_range_ff;
   logic                 s1_rise_ff;
   logic                 s1_fall_ff;
   logic [TIME_W-1:0]    s1_ts_ff;
   entry_type            rd_data_ff;
   logic                 written_rd_ff;
   logic                 fwd_hit_ff, fwd_hit_in;
   entry_type            fwd_data_ff;
   logic                 s1_adv;

   // modify
   entry_type         cur;
   entry_type         nxt;
   logic [TIME_W-1:0] pulse_w;
   logic              cap;
   logic              mem_we;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [CHANNEL_W-1:0] out_channel_ff;
   logic [WIDTH_W-1:0]   out_width_ff;
   logic [COUNT_W-1:0]   out_count_ff;
   logic                 out_has_ff;
   logic                 out_cap_ff;
   logic                 out_ign_ff;

   assign req_ext      = {{IDX_W{1'b0}}, req_ch.channel};
   assign req_addr     = req_ext[IDX_W-1:0];
   assign req_in_range = {{(CMP_W-CHANNEL_W){1'b0}}, req_ch.channel} < CMP_W'(CHANNELS);

   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   // a write leaving the stage misses the read issued in the same cycle
   assign fwd_hit_in = s1_adv && mem_we && (s1_addr_ff == req_addr);

   always_comb begin
      if (fwd_hit_ff) begin
         cur = fwd_data_ff;
      end else if (written_rd_ff) begin
         cur = rd_data_ff;
      end else begin
         cur = '0;
      end
   end

   assign pulse_w = s1_ts_ff - cur.rise_time;

   always_comb begin
      nxt = cur;
      cap = 1'b0;
      if (csr_q.monitor_enable) begin
         if (s1_rise_ff) begin
            nxt.rise_time = s1_ts_ff;
            nxt.rise_seen = 1'b1;
         end else if (s1_fall_ff && cur.rise_seen) begin
            nxt.rise_seen = 1'b0;
            if (pulse_w > {{(TIME_W-WIDTH_W){1'b0}}, csr_q.min_width_us} &&
                pulse_w < {{(TIME_W-WIDTH_W){1'b0}}, csr_q.max_width_us}) begin
               nxt.width       = pulse_w[WIDTH_W-1:0];
               nxt.count       = cur.count + COUNT_W'(1);
               nxt.width_valid = 1'b1;
               cap             = 1'b1;
            end
         end
      end
   end

   assign mem_we       = s1_adv && s1_in_range_ff && csr_q.monitor_enable;
   assign out_valid_in = s1_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[s1_addr_ff] <= nxt;
      end
      if (req_acc) begin
         rd_data_ff <= mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         written_rd_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            written_ff[s1_addr_ff] <= 1'b1;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (req_acc) begin
            fwd_hit_ff    <= fwd_hit_in;
            written_rd_ff <= req_in_range && written_ff[req_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_channel_ff  <= req_ch.channel;
         s1_addr_ff     <= req_addr;
         s1_in_range_ff <= req_in_range;
         s1_rise_ff     <= req_ch.rise_event;
         s1_fall_ff     <= req_ch.fall_event;
         s1_ts_ff       <= req_ch.timestamp_us;
         fwd_data_ff    <= nxt;
      end
      if (s1_adv) begin
         out_channel_ff <= s1_channel_ff;
         out_ign_ff     <= !csr_q.monitor_enable;
         if (s1_in_range_ff) begin
            out_width_ff <= nxt.width;
            out_count_ff <= nxt.count;
            out_has_ff   <= nxt.width_valid;
            out_cap_ff   <= cap;
         end else begin
            out_width_ff <= '0;
            out_count_ff <= '0;
            out_has_ff   <= 1'b0;
            out_cap_ff   <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.channel_out   = out_channel_ff;
   assign rsp_ch.high_width_us = out_width_ff;
   assign rsp_ch.accept_count  = out_count_ff;
   assign rsp_ch.width_valid   = out_has_ff;
   assign rsp_ch.captured      = out_cap_ff;
   assign rsp_ch.ignored       = out_ign_ff;

`ifndef ASSERT_OFF
   a_cap_has_pulse: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_cap_ff) |-> out_has_ff)
      else $error("captured result without width_valid");

   a_cap_not_ignored: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_cap_ff) |-> !out_ign_ff)
      else $error("captured result while monitoring disabled");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (s1_valid_ff && s1_in_range_ff))
      else $error("state write for an invalid or out-of-range channel");

   a_fwd_same_channel: assert property (@(posedge clock) disable iff (reset)
      (req_acc && fwd_hit_in) |=> (fwd_hit_ff && s1_valid_ff))
      else $error("forwarded entry lost");
`endif

endmodule

>>> src/multichannel_pulse_width_capture.sv
// Per-channel servo pulse width capture.
// req_ch carries one edge event per transaction: channel, rise_event, fall_event and a
// free-running 32-bit microsecond timestamp. rsp_ch returns exactly one transaction per
// event with the channel's stored width, accept count, width_valid flag, and whether this
// event captured a width or was ignored because monitoring is off.
// csr_we/csr_index/csr_wdata write monitor_enable, min_width_us and max_width_us; write
// them only while no transaction is in flight.
// A request accepted into the read stage moves to the response register, held valid
// until rsp_ch takes it. Throughput: one event per cycle while rsp_ch is ready, set by
// the single read-modify-write pass over the channel state memory; back-to-back
// events on the same channel are forwarded from the write stage to the read stage.
// Reset (synchronous, active high) clears all channel state through per-entry written
// flags and restores the register defaults (disabled, 500, 2500).
// When rsp_ch stalls, the response register holds its transaction and one more event
// waits in the read stage; req_ch.ready drops until the output drains.
module multichannel_pulse_width_capture import mpwc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   mpwc_req_if.sink               req_ch,
   mpwc_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_type csr_q;

   mpwc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_q     (csr_q)
   );

   mpwc_core #(
      .CHANNELS (CHANNELS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .csr_q  (csr_q),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
